@@ hw/rtl/pcode_stack_machine_step_defines.svh @@
// Assertion macros for the p-code stack machine
`ifndef PCODE_STACK_MACHINE_STEP_DEFINES_SVH
`define PCODE_STACK_MACHINE_STEP_DEFINES_SVH
// Property that holds at every edge outside reset
`define PSM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("psm assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent
`define PSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psm assertion failed");
`endif

@@ hw/rtl/psm_pkg.sv @@
// Package: constants, widths and opcode codes of the p-code stack machine
package psm_pkg;
  localparam int unsigned StackDepth = 1024;
  localparam int unsigned SaveDepth  = 4096;
  localparam int unsigned CodeDepth  = 4096;
  localparam int unsigned SaW = $clog2(StackDepth);
  localparam int unsigned JaW = $clog2(SaveDepth);
  localparam int unsigned CaW = $clog2(CodeDepth);
  localparam logic [7:0] NewlineLevel = 8'd255;

  localparam logic [3:0] OpLit  = 4'd0;
  localparam logic [3:0] OpOpr  = 4'd1;
  localparam logic [3:0] OpLod  = 4'd2;
  localparam logic [3:0] OpSto  = 4'd3;
  localparam logic [3:0] OpCal  = 4'd4;
  localparam logic [3:0] OpInt  = 4'd5;
  localparam logic [3:0] OpJmp  = 4'd6;
  localparam logic [3:0] OpJpc  = 4'd7;
  localparam logic [3:0] OpPrt  = 4'd8;
  localparam logic [3:0] OpLoda = 4'd9;
  localparam logic [3:0] OpLea  = 4'd10;
  localparam logic [3:0] OpStoa = 4'd11;
  localparam logic [3:0] OpLift = 4'd12;
  localparam logic [3:0] OpJbg  = 4'd13;
  localparam logic [3:0] OpJbs  = 4'd14;

  localparam logic [31:0] OprRet = 32'd0;
  localparam logic [31:0] OprNeg = 32'd1;
  localparam logic [31:0] OprAdd = 32'd2;
  localparam logic [31:0] OprSub = 32'd3;
  localparam logic [31:0] OprMul = 32'd4;
  localparam logic [31:0] OprDiv = 32'd5;
  localparam logic [31:0] OprOdd = 32'd6;
  localparam logic [31:0] OprEq  = 32'd8;
  localparam logic [31:0] OprNe  = 32'd9;
  localparam logic [31:0] OprLt  = 32'd10;
  localparam logic [31:0] OprGe  = 32'd11;
  localparam logic [31:0] OprGt  = 32'd12;
  localparam logic [31:0] OprLe  = 32'd13;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [7:0]  level_diff;
    logic [31:0] operand;
  } instr_t;

  typedef struct packed {
    logic [CaW-1:0] next_pc;
    logic           print_valid;
    logic [31:0]    print_value;
    logic           newline;
    logic           halted;
    logic           divide_error;
  } result_t;

  typedef struct packed {
    logic        start;
    logic        negate;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage

@@ hw/rtl/psm_if.sv @@
// Valid/ready channel interfaces for instructions and results
interface psm_instr_if;
  import psm_pkg::*;
  logic   valid;
  logic   ready;
  instr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psm_result_if;
  import psm_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/psm_ram.sv @@
// Generic single-port synchronous RAM with registered read data
module psm_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

@@ hw/rtl/psm_div.sv @@
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle
module psm_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psm_pkg::div_req_t    req_i,
  output psm_pkg::div_rsp_t    rsp_o
);
  import psm_pkg::*;
  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [31:0] quo_q, den_q;
  logic [32:0] rem_q;
  logic        neg_q;
  logic [32:0] rem_sh, rem_sub;
  logic        fin_q;

  assign rem_sh  = {rem_q[31:0], quo_q[31]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd32;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
      neg_q <= req_i.negate;
    end else if (busy_q) begin
      if (!rem_sub[32]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign rsp_o.done     = fin_q;
  assign rsp_o.quotient = neg_q ? (32'd0 - quo_q) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fin_q <= 1'b0;
    else fin_q <= busy_q && cnt_q == 6'd1;
  end
endmodule

@@ hw/rtl/pcode_stack_machine_step.sv @@
// Top level: p-code stack machine executing one instruction per transfer
//
// Channels: in_i carries one instruction (opcode, level_diff, operand);
// out_o returns one result (next_pc, print fields, halted, divide_error)
// per instruction, in order. An instruction is taken when in valid and ready
// are high at a clock edge; a result likewise on out.
// Sequencing: a sequencer runs each instruction through the stack memory, one
// access (address, then registered read) at a time. Each static-link step
// adds a walk read, CAL writes three words, JBS/JBG access three save-buffer
// words, and DIV waits on the bit-serial divider.
// Throughput: one instruction at a time; the next is taken only after the
// registered result has transferred, so a stalled receiver stalls the input.
// Reset: top 3, base 1, pc 0. After reset a clearing pass writes zero to
// stack entries 1 to 3 before the first instruction is taken.
// The save buffer is not cleared.
module pcode_stack_machine_step (
  input  logic  clk_i,
  input  logic  rst_ni,
  psm_instr_if.sink    in_i,
  psm_result_if.source out_o
);
  import psm_pkg::*;
  `include "pcode_stack_machine_step_defines.svh"

  localparam logic [4:0] SClr   = 5'd0;
  localparam logic [4:0] SIdle  = 5'd1;
  localparam logic [4:0] SRdT   = 5'd2;  // read mem[t]
  localparam logic [4:0] SRdB   = 5'd3;  // read mem[t-1], keep y
  localparam logic [4:0] SExec  = 5'd4;  // have x,y: decide
  localparam logic [4:0] SWalk  = 5'd5;  // link walk read issued
  localparam logic [4:0] SWalkW = 5'd6;
  localparam logic [4:0] SAcc   = 5'd7;  // final access
  localparam logic [4:0] SAccW  = 5'd8;
  localparam logic [4:0] SDiv   = 5'd9;
  localparam logic [4:0] SW1    = 5'd10;
  localparam logic [4:0] SW2    = 5'd11;
  localparam logic [4:0] SW3    = 5'd12;
  localparam logic [4:0] SRet1  = 5'd13;
  localparam logic [4:0] SRet2  = 5'd14;
  localparam logic [4:0] SRet3  = 5'd15;
  localparam logic [4:0] SJ1    = 5'd16;
  localparam logic [4:0] SJ2    = 5'd17;
  localparam logic [4:0] SJ3    = 5'd18;
  localparam logic [4:0] SJ4    = 5'd19;
  localparam logic [4:0] SDone  = 5'd20;
  localparam logic [4:0] SIndW  = 5'd21;

  logic [4:0]     st_q, st_d;
  logic [SaW-1:0] t_q, t_d, b_q, b_d, wb_q, wb_d;
  logic [CaW-1:0] pc_q, pc_d, npc_q, npc_d;
  logic [7:0]     lv_q, lv_d;
  instr_t         ins_q, ins_d;
  logic [31:0]    y_q, y_d, x_q, x_d;
  logic [JaW-1:0] k_q, k_d;
  logic [1:0]     clr_q, clr_d;
  logic           pv_d, pv_q, nl_d, nl_q, err_d, err_q;

  logic           s_we, j_we;
  logic [SaW-1:0] s_addr;
  logic [JaW-1:0] j_addr;
  logic [31:0]    s_wd, j_wd, s_rd, j_rd;

  div_req_t dreq;
  div_rsp_t drsp;

  logic           ov_q;
  result_t        ores_q;

  psm_ram #(.Depth(StackDepth), .Width(32)) u_stack (
    .clk_i, .we_i(s_we), .addr_i(s_addr), .wdata_i(s_wd), .rdata_o(s_rd));
  psm_ram #(.Depth(SaveDepth), .Width(32)) u_save (
    .clk_i, .we_i(j_we), .addr_i(j_addr), .wdata_i(j_wd), .rdata_o(j_rd));
  psm_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic [31:0] xs_abs, ys_abs, mag_prod, odd_r, cmp_r;
  logic        xs, ys;
  assign xs = x_q[31];
  assign ys = y_q[31];
  assign xs_abs = xs ? (32'd0 - x_q) : x_q;
  assign ys_abs = ys ? (32'd0 - y_q) : y_q;
  assign odd_r  = (y_q[0] == 1'b0) ? 32'd0 : (ys ? 32'hFFFF_FFFF : 32'd1);

  always_comb begin
    cmp_r = 32'd0;
    case (ins_q.operand)
      OprEq: cmp_r = {31'd0, x_q == y_q};
      OprNe: cmp_r = {31'd0, x_q != y_q};
      OprLt: cmp_r = {31'd0, $signed(x_q) < $signed(y_q)};
      OprGe: cmp_r = {31'd0, $signed(x_q) >= $signed(y_q)};
      OprGt: cmp_r = {31'd0, $signed(x_q) > $signed(y_q)};
      OprLe: cmp_r = {31'd0, $signed(x_q) <= $signed(y_q)};
      default: cmp_r = 32'd0;
    endcase
  end
  assign mag_prod = x_q * y_q;

  logic is_binary;
  always_comb begin
    is_binary = 1'b0;
    case (ins_q.operand)
      OprAdd, OprSub, OprMul, OprEq, OprNe, OprLt, OprGe, OprGt, OprLe:
        is_binary = 1'b1;
      default: is_binary = 1'b0;
    endcase
  end

  logic [SaW-1:0] opnd_s;
  assign opnd_s = ins_q.operand[SaW-1:0];

  always_comb begin
    st_d = st_q; t_d = t_q; b_d = b_q; wb_d = wb_q; pc_d = pc_q; npc_d = npc_q;
    lv_d = lv_q; ins_d = ins_q; y_d = y_q; x_d = x_q; k_d = k_q; clr_d = clr_q;
    pv_d = pv_q; nl_d = nl_q; err_d = err_q;
    s_we = 1'b0; s_addr = t_q; s_wd = 32'd0;
    j_we = 1'b0; j_addr = k_q; j_wd = 32'd0;
    dreq = '0;
    case (st_q)
      SClr: begin
        s_we = 1'b1; s_addr = SaW'(clr_q) + SaW'(1); s_wd = 32'd0;
        clr_d = clr_q + 2'd1;
        if (clr_q == 2'd2) st_d = SIdle;
      end
      SIdle: begin
        if (in_i.valid && !ov_q) begin
          ins_d = in_i.data; lv_d = in_i.data.level_diff;
          npc_d = pc_q + CaW'(1);
          pv_d = 1'b0; nl_d = 1'b0; err_d = 1'b0; wb_d = b_q;
          s_addr = t_q;
          st_d = SRdT;
          case (in_i.data.opcode)
            OpLit: begin
              t_d = t_q + SaW'(1); s_we = 1'b1; s_addr = t_q + SaW'(1);
              s_wd = in_i.data.operand; st_d = SDone;
            end
            OpInt: begin t_d = t_q + in_i.data.operand[SaW-1:0]; st_d = SDone; end
            OpJmp: begin npc_d = in_i.data.operand[CaW-1:0]; st_d = SDone; end
            OpPrt: if (in_i.data.level_diff == NewlineLevel) begin
              nl_d = 1'b1; st_d = SDone;
            end
            OpLod, OpSto, OpCal, OpLea: begin
              if (in_i.data.level_diff == 8'd0) begin
                st_d = (in_i.data.opcode == OpSto) ? SRdT : SAcc;
              end else begin
                s_addr = b_q; st_d = SWalk;
              end
            end
            OpLift: begin
              s_addr = t_q - in_i.data.operand[SaW-1:0]; st_d = SAccW;
            end
            OpOpr: if (in_i.data.operand == OprRet) begin
              t_d = b_q - SaW'(1); s_addr = b_q + SaW'(2); st_d = SRet1;
            end
            OpLoda, OpJpc, OpStoa, OpJbg, OpJbs: ;
            default: st_d = SDone;
          endcase
        end
      end
      SWalk: begin
        s_addr = s_rd[SaW-1:0]; wb_d = s_rd[SaW-1:0];
        lv_d = lv_q - 8'd1;
        if (lv_q == 8'd1) begin
          st_d = (ins_q.opcode == OpSto) ? SRdT : SAcc;
          s_addr = t_q;
        end
      end
      SAcc: begin
        // wb_q holds the walked base
        case (ins_q.opcode)
          OpLod: begin s_addr = wb_q + opnd_s; st_d = SAccW; end
          OpLea: begin
            t_d = t_q + SaW'(1); s_we = 1'b1; s_addr = t_q + SaW'(1);
            s_wd = 32'(wb_q) + ins_q.operand; st_d = SDone;
          end
          OpCal: begin
            s_we = 1'b1; s_addr = t_q + SaW'(1); s_wd = 32'(wb_q); st_d = SW2;
          end
          default: st_d = SDone;
        endcase
      end
      SW2: begin
        s_we = 1'b1; s_addr = t_q + SaW'(2); s_wd = 32'(b_q); st_d = SW3;
      end
      SW3: begin
        s_we = 1'b1; s_addr = t_q + SaW'(3); s_wd = 32'(npc_q);
        b_d = t_q + SaW'(1); npc_d = ins_q.operand[CaW-1:0]; st_d = SDone;
      end
      SAccW: begin
        t_d = t_q + SaW'(1); s_we = 1'b1; s_addr = t_q + SaW'(1); s_wd = s_rd;
        st_d = SDone;
      end
      SRdT: begin
        y_d = s_rd;
        case (ins_q.opcode)
          OpSto: begin
            s_we = 1'b1; s_addr = wb_q + opnd_s; s_wd = s_rd;
            t_d = t_q - SaW'(1); st_d = SDone;
          end
          OpJpc: begin
            if (s_rd == 32'd0) npc_d = ins_q.operand[CaW-1:0];
            t_d = t_q - SaW'(1); st_d = SDone;
          end
          OpPrt: begin pv_d = 1'b1; t_d = t_q - SaW'(1); st_d = SDone; end
          OpLoda: begin s_addr = s_rd[SaW-1:0]; st_d = SIndW; end
          OpOpr: begin
            if (ins_q.operand == OprNeg) begin
              s_we = 1'b1; s_wd = 32'd0 - s_rd; st_d = SDone;
            end else if (ins_q.operand == OprOdd) begin
              s_addr = t_q; st_d = SRdB;
            end else begin
              s_addr = t_q - SaW'(1); st_d = SRdB;
            end
          end
          default: begin s_addr = t_q - SaW'(1); st_d = SRdB; end
        endcase
      end
      SIndW: begin
        s_we = 1'b1; s_addr = t_q; s_wd = s_rd; st_d = SDone;
      end
      SRdB: begin
        x_d = s_rd; st_d = SExec;
      end
      SExec: begin
        st_d = SDone;
        case (ins_q.opcode)
          OpStoa: begin
            s_we = 1'b1; s_addr = x_q[SaW-1:0]; s_wd = y_q; t_d = t_q - SaW'(2);
          end
          OpJbs: begin
            k_d = x_q[JaW-1:0]; j_we = 1'b1; j_addr = x_q[JaW-1:0]; j_wd = y_q;
            st_d = SJ1;
          end
          OpJbg: begin
            k_d = x_q[JaW-1:0]; j_addr = x_q[JaW-1:0] + JaW'(1); st_d = SJ2;
          end
          default: begin
            if (ins_q.operand == OprOdd) begin
              s_we = 1'b1; s_wd = odd_r;
            end else if (ins_q.operand == OprDiv) begin
              if (y_q == 32'd0) begin
                t_d = t_q - SaW'(1); err_d = 1'b1; npc_d = '0;
              end else begin
                dreq.start = 1'b1; dreq.negate = xs ^ ys;
                dreq.dividend = xs_abs; dreq.divisor = ys_abs; st_d = SDiv;
              end
            end else if (is_binary) begin
              s_we = 1'b1; s_addr = t_q - SaW'(1); t_d = t_q - SaW'(1);
              s_wd = (ins_q.operand == OprAdd) ? x_q + y_q :
                     (ins_q.operand == OprSub) ? x_q - y_q :
                     (ins_q.operand == OprMul) ? mag_prod : cmp_r;
            end
          end
        endcase
      end
      SDiv: if (drsp.done) begin
        s_we = 1'b1; s_addr = t_q - SaW'(1); t_d = t_q - SaW'(1);
        s_wd = drsp.quotient; st_d = SDone;
      end
      SJ1: begin
        j_we = 1'b1; j_addr = k_q + JaW'(1); j_wd = 32'(t_q - SaW'(2)); st_d = SJ3;
      end
      SJ3: begin
        j_we = 1'b1; j_addr = k_q + JaW'(2); j_wd = 32'(b_q);
        t_d = t_q - SaW'(2); st_d = SDone;
      end
      SJ2: begin
        t_d = j_rd[SaW-1:0] + SaW'(1); j_addr = k_q + JaW'(2); st_d = SJ4;
      end
      SJ4: begin
        b_d = j_rd[SaW-1:0]; j_addr = k_q; st_d = SW1;
      end
      SW1: begin
        j_addr = k_q; st_d = SRet3;
      end
      SRet3: begin
        npc_d = j_rd[CaW-1:0];
        s_we = 1'b1; s_addr = t_q; s_wd = y_q; st_d = SDone;
      end
      SRet1: begin
        s_addr = b_q + SaW'(1); npc_d = s_rd[CaW-1:0]; st_d = SRet2;
      end
      SRet2: begin
        b_d = s_rd[SaW-1:0]; st_d = SDone;
      end
      SDone: begin
        pc_d = npc_q; st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  assign in_i.ready = (st_q == SIdle) && !ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClr; t_q <= SaW'(3); b_q <= SaW'(1); pc_q <= '0; clr_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d; t_q <= t_d; b_q <= b_d; pc_q <= pc_d; clr_q <= clr_d;
      if (st_q == SDone) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_q <= wb_d; npc_q <= npc_d; lv_q <= lv_d; ins_q <= ins_d;
    y_q <= y_d; x_q <= x_d; k_q <= k_d; pv_q <= pv_d; nl_q <= nl_d; err_q <= err_d;
    if (st_q == SDone) begin
      ores_q.next_pc      <= npc_q;
      ores_q.print_valid  <= pv_q;
      ores_q.print_value  <= pv_q ? y_q : 32'd0;
      ores_q.newline      <= nl_q;
      ores_q.halted       <= (npc_q == '0) || err_q;
      ores_q.divide_error <= err_q;
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = ores_q;

  `PSM_ASSERT(a_no_take_while_full, !(in_i.ready && out_o.valid))
  `PSM_ASSERT_NEXT(a_done_fills_out, st_q == SDone, out_o.valid)
  `PSM_ASSERT(a_err_halts, !(out_o.valid && out_o.data.divide_error) || out_o.data.halted)
endmodule
